/* rtl/i2a_pkg.sv */
// Package for the integer to ASCII digit converter.
// Request/result types, character constants, state encoding.
// No dependencies.
package i2a_pkg;

    localparam int VALUE_W  = 64;
    localparam int DIGITS   = 20;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 7;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int DIGCNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0]  CH_MINUS = 7'h2D;
    localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               base_hex;
        logic               signed_mode;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE)
            c = CH_ZERO + CHAR_W'(d);
        else
            c = CH_LOWA + CHAR_W'(d - DEC_BASE);
        return c;
    endfunction

endpackage

/* rtl/integer_to_ascii_digits_top.sv */
// Integer to ASCII digit converter, top level.
// Shift-add-3 binary to BCD (or plain nibble shift for hex), then digit emission.
// Depends on i2a_pkg.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the last character has been shown. The value is shifted into a
// 20-digit register one bit per cycle. Leading zero digits are then dropped
// at one per cycle until the first digit to show is found. Then each
// character, the minus sign first when present, is shown for one cycle with
// strobe high. With start held high the next request is taken in the same
// cycle that busy falls. Results cannot be held off: the receiver must take
// each one in the cycle it appears.
module integer_to_ascii_digits_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  i2a_pkg::req_t    req,
    output logic             busy,
    output logic             strobe,
    output i2a_pkg::result_t result
);

    localparam int DREG_W = i2a_pkg::DIGITS * i2a_pkg::DIGIT_W;

    i2a_pkg::state_t state_reg, state_next;

    logic [i2a_pkg::VALUE_W-1:0]  mag_reg, mag_next;
    logic [DREG_W-1:0]            dig_reg, dig_next;
    logic [DREG_W-1:0]            dig_adj;
    logic [i2a_pkg::BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [i2a_pkg::DIGCNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic                         neg_reg, neg_next;
    logic                         hex_reg, hex_next;
    logic [i2a_pkg::DIGIT_W-1:0]  top_digit;
    logic                         accept;
    logic                         req_neg;

    assign accept    = start && !busy;
    assign req_neg   = req.signed_mode && req.value[i2a_pkg::VALUE_W-1];
    assign top_digit = dig_reg[DREG_W-1 -: i2a_pkg::DIGIT_W];

    // add-3 correction on every digit >= 5 (decimal only)
    always_comb
    begin
        logic [i2a_pkg::DIGIT_W-1:0] d;
        for (int i = 0; i < i2a_pkg::DIGITS; i++)
        begin
            d = dig_reg[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W];
            if (!hex_reg && d >= 4'd5)
                d = d + 4'd3;
            dig_adj[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] = d;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = i2a_pkg::ST_CONV;
            end
            i2a_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == i2a_pkg::BITCNT_W'(i2a_pkg::VALUE_W - 1))
                    state_next = i2a_pkg::ST_SCAN;
            end
            i2a_pkg::ST_SCAN:
            begin
                if (top_digit != '0 || dig_cnt_reg == i2a_pkg::DIGCNT_W'(1))
                    state_next = neg_reg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_SIGN:
            begin
                state_next = i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT:
            begin
                if (dig_cnt_reg == i2a_pkg::DIGCNT_W'(1))
                    state_next = i2a_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        hex_next     = hex_reg;
        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next     = req_neg ? (i2a_pkg::VALUE_W'(0) - req.value) : req.value;
                    dig_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = i2a_pkg::DIGCNT_W'(i2a_pkg::DIGITS);
                    neg_next     = req_neg;
                    hex_next     = req.base_hex;
                end
            end
            i2a_pkg::ST_CONV:
            begin
                dig_next     = {dig_adj[DREG_W-2:0], mag_reg[i2a_pkg::VALUE_W-1]};
                mag_next     = {mag_reg[i2a_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            i2a_pkg::ST_SCAN:
            begin
                if (top_digit == '0 && dig_cnt_reg != i2a_pkg::DIGCNT_W'(1))
                begin
                    dig_next     = dig_reg << i2a_pkg::DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            i2a_pkg::ST_SIGN:
            begin
            end
            i2a_pkg::ST_EMIT:
            begin
                dig_next     = dig_reg << i2a_pkg::DIGIT_W;
                dig_cnt_next = dig_cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy             = (state_reg != i2a_pkg::ST_IDLE);
        strobe           = 1'b0;
        result.char_code = i2a_pkg::digit_char(top_digit);
        result.last_char = 1'b0;
        unique case (state_reg)
            i2a_pkg::ST_SIGN:
            begin
                strobe           = 1'b1;
                result.char_code = i2a_pkg::CH_MINUS;
            end
            i2a_pkg::ST_EMIT:
            begin
                strobe           = 1'b1;
                result.last_char = (dig_cnt_reg == i2a_pkg::DIGCNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= i2a_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            neg_reg     <= 1'b0;
            hex_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            neg_reg     <= neg_next;
            hex_reg     <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dig_reg <= dig_next;
    end

`ifndef SYNTH
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_char |=> !busy)
        else $error("still busy after last character");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !strobe)
        else $error("request not taken up");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.char_code == i2a_pkg::CH_MINUS |-> !result.last_char)
        else $error("minus sign flagged as last");

    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == i2a_pkg::ST_SCAN) |-> $past(state_reg) == i2a_pkg::ST_CONV
            && $past(bit_cnt_reg) == i2a_pkg::BITCNT_W'(i2a_pkg::VALUE_W - 1))
        else $error("conversion ended early");
`endif

endmodule
